// ----- hw/rtl/sha1sh_pkg.sv -----
package sha1sh_pkg;

   localparam int unsigned ROUNDS     = 80;
   localparam int unsigned SCHED_LEN  = 16;
   localparam int unsigned DIGEST_LEN = 5;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] H_INIT [DIGEST_LEN] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_00_19 = 32'h5A827999;
   localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
   localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
   localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } work_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // one compression round
   function automatic work_type round_step(input work_type s, input logic [31:0] w,
                                           input logic [6:0] t);
      logic [31:0] f;
      logic [31:0] k;
      work_type    r;
      case (t) inside
         [7'd0:7'd19]: begin
            f = (s.b & s.c) | (~s.b & s.d);
            k = K_00_19;
         end
         [7'd20:7'd39]: begin
            f = s.b ^ s.c ^ s.d;
            k = K_20_39;
         end
         [7'd40:7'd59]: begin
            f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
            k = K_40_59;
         end
         default: begin
            f = s.b ^ s.c ^ s.d;
            k = K_60_79;
         end
      endcase
      r.a = rotl(s.a, 5) + f + s.e + w + k;
      r.b = s.a;
      r.c = rotl(s.b, 30);
      r.d = s.c;
      r.e = s.d;
      round_step = r;
   endfunction

endpackage

// ----- hw/rtl/sha1sh_if.sv -----
interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word0;
   logic [31:0] digest_word1;
   logic [31:0] digest_word2;
   logic [31:0] digest_word3;
   logic [31:0] digest_word4;

   modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                   digest_word4, input ready);
   modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                   digest_word4, output ready);
endinterface

// ----- hw/rtl/sha1_stream_hasher.sv -----
// sha1_stream_hasher: streaming sha-1 digest engine
//
// req channel: one transaction carries at most one message byte (byte_present)
// and may close the message (end_of_message). a transaction with neither
// bit set is a no-op. rsp channel: one transaction per message, holding the
// 160-bit digest as five 32-bit words, word0 first, big-endian.
//
// flow: a byte transaction is taken while idle; the byte that fills a 64-byte
// block starts a compression (80 rounds, one per cycle, then the chaining add).
// closing a message pads one byte per cycle up to the end of the last block,
// pausing while each full block is compressed (one or two), then posts the digest.
// the block buffer is a chain of 16 word cells that shifts as each word is
// packed and shifts once per round, taking in the next schedule word.
// reset: synchronous, active high; chaining words go to the sha-1 initial
// values, counts clear, no digest pending. after each digest the engine
// returns to that state and starts a new message.
// stall: the digest sits in an output register; if rsp is stalled the
// engine keeps taking bytes of the next message and only waits when it
// has a second digest ready.
module sha1_stream_hasher
   import sha1sh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sha1sh_req_if.sink   req_ch,
   sha1sh_rsp_if.source rsp_ch
);

   // control state
   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;        // bytes in the current block
   logic [63:0] bitcnt_ff, bitcnt_in;    // message length in bits, wraps
   logic [6:0]  rnd_ff, rnd_in;          // round index
   logic        pad_on_ff, pad_on_in;    // message closed, padding underway
   logic        mark_ff, mark_in;        // 0x80 marker still to go
   logic        len_on_ff, len_on_in;    // length bytes underway
   logic [2:0]  len_idx_ff, len_idx_in;  // next length byte, msb first
   logic        last_blk_ff, last_blk_in;
   logic [31:0] h_ff [DIGEST_LEN];
   logic [31:0] h_in [DIGEST_LEN];
   logic        rsp_valid_ff, rsp_valid_in;

   // payload state
   work_type    work_ff, work_in;
   logic [23:0] acc_ff, acc_in;          // partial word being packed
   logic [31:0] dig_ff [DIGEST_LEN];
   logic [31:0] dig_in [DIGEST_LEN];

   // schedule chain
   logic [31:0] cell_q [SCHED_LEN];
   logic [31:0] tail_word;
   logic [31:0] next_w;
   logic        shift_en;

   // byte push path
   logic        push_en;
   logic [7:0]  push_byte;
   logic [63:0] len_shift;
   logic        can_post;

   assign can_post   = !rsp_valid_ff || rsp_ch.ready;
   assign len_shift  = bitcnt_ff << {len_idx_ff, 3'b000};
   assign next_w     = rotl(cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0], 1);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bitcnt_in    = bitcnt_ff;
      rnd_in       = rnd_ff;
      pad_on_in    = pad_on_ff;
      mark_in      = mark_ff;
      len_on_in    = len_on_ff;
      len_idx_in   = len_idx_ff;
      last_blk_in  = last_blk_ff;
      h_in         = h_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      work_in      = work_ff;
      acc_in       = acc_ff;
      dig_in       = dig_ff;
      push_en      = 1'b0;
      push_byte    = req_ch.msg_byte;
      req_ch.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // ready is always high here, so valid alone marks a transaction
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.byte_present) begin
                  push_en   = 1'b1;
                  bitcnt_in = bitcnt_ff + 64'd8;
               end
               if (req_ch.end_of_message) begin
                  pad_on_in = 1'b1;
                  mark_in   = 1'b1;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (mark_ff) begin
               push_byte = PAD_MARK;
               mark_in   = 1'b0;
            end else if (len_on_ff || fill_ff == 6'd56) begin
               // length field, big-endian
               push_byte  = len_shift[63:56];
               len_on_in  = 1'b1;
               len_idx_in = len_idx_ff + 3'd1;
               if (len_idx_ff == 3'd7) begin
                  last_blk_in = 1'b1;
               end
            end else begin
               push_byte = 8'h00;
            end
         end
         ST_ROUND: begin
            work_in = round_step(work_ff, cell_q[0], rnd_ff);
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0] = h_ff[0] + work_ff.a;
            h_in[1] = h_ff[1] + work_ff.b;
            h_in[2] = h_ff[2] + work_ff.c;
            h_in[3] = h_ff[3] + work_ff.d;
            h_in[4] = h_ff[4] + work_ff.e;
            if (last_blk_ff) begin
               state_in = ST_DONE;
            end else if (pad_on_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            // post the digest and start over with a fresh message
            if (can_post) begin
               dig_in       = h_ff;
               rsp_valid_in = 1'b1;
               h_in         = H_INIT;
               bitcnt_in    = '0;
               pad_on_in    = 1'b0;
               mark_in      = 1'b0;
               len_on_in    = 1'b0;
               len_idx_in   = '0;
               last_blk_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shared byte packing; a full block kicks off compression
      if (push_en) begin
         fill_in = fill_ff + 6'd1;
         acc_in  = {acc_ff[15:0], push_byte};
         if (fill_ff == 6'd63) begin
            work_in  = '{a: h_ff[0], b: h_ff[1], c: h_ff[2], d: h_ff[3], e: h_ff[4]};
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
      end
   end

   assign shift_en  = (push_en && fill_ff[1:0] == 2'b11) || state_ff == ST_ROUND;
   assign tail_word = (state_ff == ST_ROUND) ? next_w : {acc_ff, push_byte};

   for (genvar i = 0; i < SCHED_LEN; i++) begin : g_cell
      sha1sh_wcell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .word_in  ((i == SCHED_LEN - 1) ? tail_word : cell_q[(i + 1) % SCHED_LEN]),
         .word_out (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bitcnt_ff    <= '0;
         rnd_ff       <= '0;
         pad_on_ff    <= 1'b0;
         mark_ff      <= 1'b0;
         len_on_ff    <= 1'b0;
         len_idx_ff   <= '0;
         last_blk_ff  <= 1'b0;
         h_ff         <= H_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bitcnt_ff    <= bitcnt_in;
         rnd_ff       <= rnd_in;
         pad_on_ff    <= pad_on_in;
         mark_ff      <= mark_in;
         len_on_ff    <= len_on_in;
         len_idx_ff   <= len_idx_in;
         last_blk_ff  <= last_blk_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      acc_ff  <= acc_in;
      dig_ff  <= dig_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.digest_word0 = dig_ff[0];
   assign rsp_ch.digest_word1 = dig_ff[1];
   assign rsp_ch.digest_word2 = dig_ff[2];
   assign rsp_ch.digest_word3 = dig_ff[3];
   assign rsp_ch.digest_word4 = dig_ff[4];

`ifndef ASSERT_OFF
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> rnd_ff <= LAST_ROUND)
      else $error("round index past last round");

   a_round_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == LAST_ROUND) |=> state_ff == ST_ADD)
      else $error("compression did not end after last round");

   a_done_block_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> (fill_ff == 6'd0 && !mark_ff && len_idx_ff == 3'd0))
      else $error("digest posted with padding incomplete");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("digest posted outside done state");
`endif

endmodule

// ----- hw/rtl/sha1sh_wcell.sv -----
// one word of the message schedule window
module sha1sh_wcell (
   input  logic        clock,
   input  logic        shift_en,
   input  logic [31:0] word_in,
   output logic [31:0] word_out
);

   logic [31:0] word_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ----- dv/tb_sha1_stream_hasher.sv -----
`timescale 1ns / 100ps

module tb_sha1_stream_hasher
   import sha1sh_pkg::*;
();

   // long receiver hold-off used to back the engine up into the input side
   localparam int unsigned HOLD_CYCLES  = 600;
   // cycles with no transaction on either channel before the run is declared hung
   localparam int unsigned STALL_LIMIT  = 5000;
   // drain time after the last digest, covers a full two-block close
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned TARGET_ITEMS = 1650;
   // after this many items both sides run without idling
   localparam int unsigned QUIET_AFTER  = 1450;

   typedef logic [32*DIGEST_LEN-1:0] digest_bits_type;

   // running sha-1 of the current message plus the digests still owed by the dut
   class digest_scoreboard;
      logic [31:0]     chain [DIGEST_LEN];
      logic [7:0]      block_bytes [64];
      int unsigned     fill;
      logic [63:0]     bit_len;
      digest_bits_type pending_digests [$];
      int unsigned     mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         foreach (chain[i]) chain[i] = H_INIT[i];
         fill = 0;
         bit_len = '0;
      endfunction

      function void compress_block();
         logic [31:0] w [ROUNDS];
         logic [31:0] a, b, c, d, e, f, k, t;
         for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
         for (int i = 16; i < ROUNDS; i++) begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int i = 0; i < ROUNDS; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d);
               k = K_00_19;
            end else if (i < 40) begin
               f = b ^ c ^ d;
               k = K_20_39;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_40_59;
            end else begin
               f = b ^ c ^ d;
               k = K_60_79;
            end
            t = {a[26:0], a[31:27]} + f + e + w[i] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void push_byte(logic [7:0] v);
         block_bytes[fill] = v;
         fill++;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      endfunction

      // one accepted request transaction
      function void note_request(logic [7:0] msg_byte, logic byte_present,
                                 logic end_of_message);
         logic [63:0] len;
         if (byte_present) begin
            bit_len += 64'd8;
            push_byte(msg_byte);
         end
         if (end_of_message) begin
            len = bit_len;
            push_byte(PAD_MARK);
            while (fill != 56) push_byte(8'h00);
            for (int i = 0; i < 8; i++) push_byte(len[63-8*i -: 8]);
            pending_digests.insert(pending_digests.size(),
                                   {chain[0], chain[1], chain[2], chain[3], chain[4]});
            restart();
         end
      endfunction

      // one accepted response transaction
      function void check_digest(digest_bits_type got);
         digest_bits_type want;
         if (pending_digests.size() == 0) begin
            $error("unexpected digest %h, none outstanding", got);
            mismatches++;
            return;
         end
         want = pending_digests.pop_front();
         for (int i = 0; i < DIGEST_LEN; i++) begin
            if (got[32*DIGEST_LEN-1-32*i -: 32] !== want[32*DIGEST_LEN-1-32*i -: 32]) begin
               $error("digest_word%0d expected %08h actual %08h", i,
                      want[32*DIGEST_LEN-1-32*i -: 32], got[32*DIGEST_LEN-1-32*i -: 32]);
               mismatches++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_digests.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sha1sh_req_if req_ch();
   sha1sh_rsp_if rsp_ch();

   sha1_stream_hasher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   digest_scoreboard hash_sb = new();

   int unsigned items_sent;    // transactions carrying a byte or an end of message
   int unsigned idle_cycles;
   bit          hold_digests;  // main flow asks the receiver for a long hold-off
   bit          quiet_tail;    // no idling on either side from here on

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response monitor: sample at the rising edge and compare
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         hash_sb.check_digest({rsp_ch.digest_word0, rsp_ch.digest_word1, rsp_ch.digest_word2,
                               rsp_ch.digest_word3, rsp_ch.digest_word4});
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random back-pressure bursts, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_digests) begin
            // hold counted here so the sender keeps pushing meanwhile
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_digests = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // present one request transaction from a falling edge, return at the
   // falling edge after it was taken
   task automatic send_item(input logic [7:0] msg_byte, input logic byte_present,
                            input logic end_of_message);
      req_ch.valid          = 1'b1;
      req_ch.msg_byte       = msg_byte;
      req_ch.byte_present   = byte_present;
      req_ch.end_of_message = end_of_message;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      hash_sb.note_request(msg_byte, byte_present, end_of_message);
      if (byte_present || end_of_message) items_sent++;
      @(negedge clock);
   endtask

   // sender idle burst; payload is junk while valid is low
   task automatic sender_gap(input int unsigned cycles);
      req_ch.valid          = 1'b0;
      req_ch.msg_byte       = 8'($urandom);
      req_ch.byte_present   = 1'($urandom);
      req_ch.end_of_message = 1'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet_tail && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 18));
   endtask

   // sender stops until every digest owed has come back
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (hash_sb.outstanding() != 0) @(negedge clock);
   endtask

   // one message of len bytes; closed either on the last byte or by a
   // separate end-only transaction, with a few no-op transactions mixed in
   task automatic send_message(input int unsigned len);
      bit close_on_byte;
      close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b0);
            maybe_gap();
         end
         send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
         maybe_gap();
      end
      if (!close_on_byte) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         maybe_gap();
      end
   endtask

   // mostly short messages, many around the padding edges (55/56 and
   // block multiples), now and then a long one
   function automatic int unsigned pick_length();
      int unsigned edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $urandom_range(0, 20);
      if (sel < 9) return edges[$urandom_range(0, 9)];
      return $urandom_range(0, 200);
   endfunction

   initial begin
      bit hold_done;
      bit drain_done;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.msg_byte       = 8'h00;
      req_ch.byte_present   = 1'b0;
      req_ch.end_of_message = 1'b0;
      items_sent   = 0;
      hold_digests = 1'b0;
      quiet_tail   = 1'b0;
      hold_done    = 1'b0;
      drain_done   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty message, no-op, one-byte extremes, "abc", split close
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h5a, 1'b1, 1'b0);
      send_item(8'ha5, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      wait_drained();

      // random messages
      while (items_sent < TARGET_ITEMS) begin
         if (!hold_done && items_sent >= 600) begin
            // receiver stops while short messages keep coming, so the
            // output register and the next digest back up into req
            hold_done = 1'b1;
            hold_digests = 1'b1;
            repeat (8) send_message($urandom_range(0, 4));
         end
         if (!drain_done && items_sent >= 1100) begin
            drain_done = 1'b1;
            wait_drained();
         end
         if (items_sent >= QUIET_AFTER) quiet_tail = 1'b1;
         send_message(pick_length());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hash_sb.mismatches == 0 && hash_sb.outstanding() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_if.sv
hw/rtl/sha1sh_wcell.sv
hw/rtl/sha1_stream_hasher.sv
dv/tb_sha1_stream_hasher.sv
